FILE: rtl/core/bc1pt_pkg.sv
// shared types and constants of the punch-through block encoder
package bc1pt_pkg;

  localparam int unsigned TEXELS = 16;
  localparam int unsigned IDX_W  = $clog2(TEXELS);
  localparam int unsigned SQ_W   = 16;
  localparam int unsigned ERR_W  = SQ_W + 2;

  localparam logic [7:0]        THRESH_RESET = 8'd128;
  localparam logic [TEXELS-1:0] MASK_ALL     = {TEXELS{1'b1}};
  localparam logic [IDX_W-1:0]  LAST_IDX     = IDX_W'(TEXELS - 1);

  // selector codes
  localparam logic [1:0] SEL_EP0   = 2'd0;
  localparam logic [1:0] SEL_EP1   = 2'd1;
  localparam logic [1:0] SEL_MID   = 2'd2;
  localparam logic [1:0] SEL_CLEAR = 2'd3;

  // channel 0 is red, 1 green, 2 blue
  typedef logic [2:0][7:0] rgb_t;
  typedef logic [2:0][2:0][7:0] pal_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } texel_in_t;

  typedef struct packed {
    logic [15:0] endpoint_first;
    logic [15:0] endpoint_second;
    logic [31:0] selector_bits;
    logic        all_opaque;
  } block_out_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
  } sweep_t;

endpackage

FILE: rtl/core/bc1_punch_through_block_encoder.sv
// top level of the punch-through (3-color, 1-bit alpha) 4x4 block encoder
//
// texels of one 4x4 block arrive in raster order, one transfer per cycle,
// and go into a 16-entry texel memory while the opaque per-channel min
// and max and the transparency mask build up in registers. after the 16th
// texel the endpoint state forms the two RGB565 endpoints, then a sweep
// reads the memory one texel per cycle and matches each against the
// 3-entry palette through a two-stage squared-error unit; the single read
// port of the texel memory sets the sweep length. a fully opaque block
// skips the endpoint state and the sweep and only reports all_opaque. the
// result sits in an output register, so the next block loads while it
// waits for a transfer. the input is stalled in the endpoint, sweep and
// handoff phases; handoff waits while the output register is still full.
module bc1_punch_through_block_encoder
  import bc1pt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  // texel input
  input  logic       in_valid,
  output logic       in_stall,
  input  texel_in_t  in_data,
  // block result
  output logic       out_valid,
  input  logic       out_stall,
  output block_out_t out_data,
  // threshold register
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);

  typedef enum logic [1:0] {
    S_LOAD,
    S_ENDP,
    S_SWEEP,
    S_DONE
  } state_t;

  state_t            state_r;
  logic [7:0]        thresh_r;
  logic [IDX_W-1:0]  cnt_r;        // texel position during load
  logic [IDX_W:0]    rd_cnt_r;     // read address during sweep, msb = all issued
  logic [TEXELS-1:0] mask_r;       // set bit = transparent texel
  rgb_t              min_r;
  rgb_t              max_r;
  logic [15:0]       ep0_r;
  logic [15:0]       ep1_r;
  logic [31:0]       sel_r;
  logic              opaque_r;
  sweep_t            rd_sw_r;      // tags the memory read data
  logic              out_valid_r;
  block_out_t        out_data_r;

  logic              in_xfer;
  logic              texel_clear;
  logic [TEXELS-1:0] mask_nxt;
  rgb_t              texel_rgb;
  rgb_t              lo;
  rgb_t              hi;
  logic [15:0]       c_lo;
  logic [15:0]       c_hi;
  pal_t              pal;
  logic              rd_en;
  rgb_t              rd_data;
  sweep_t            sw_out;
  logic [1:0]        sel_code;
  logic              out_load;     // finished block moves into the output register

  function automatic logic [15:0] pack565(input rgb_t c);
    return {c[0][7:3], c[1][7:2], c[2][7:3]};
  endfunction

  function automatic rgb_t expand565(input logic [15:0] c);
    rgb_t e;
    e[0] = {c[15:11], c[15:13]};
    e[1] = {c[10:5], c[10:9]};
    e[2] = {c[4:0], c[4:2]};
    return e;
  endfunction

  // texels are taken only in the load phase
  assign in_stall    = (state_r != S_LOAD);
  assign in_xfer     = in_valid && !in_stall;
  assign texel_clear = (in_data.alpha < thresh_r);
  assign texel_rgb   = {in_data.blue, in_data.green, in_data.red};
  assign mask_nxt    = mask_r | (TEXELS'(texel_clear) << cnt_r);

  // output register is free or being emptied this cycle
  assign out_load    = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  // a fully transparent block uses zero endpoints
  always_comb begin
    lo   = (mask_r == MASK_ALL) ? '0 : min_r;
    hi   = (mask_r == MASK_ALL) ? '0 : max_r;
    c_lo = pack565(lo);
    c_hi = pack565(hi);
  end

  // palette: two expanded endpoints and their floored midpoint
  always_comb begin
    pal[0] = expand565(ep0_r);
    pal[1] = expand565(ep1_r);
    for (int c = 0; c < 3; c++) begin
      pal[2][c] = 8'((9'(pal[0][c]) + 9'(pal[1][c])) >> 1);
    end
  end

  assign rd_en = (state_r == S_SWEEP) && !rd_cnt_r[IDX_W];

  bc1pt_texel_mem u_mem (
    .clk     (clk),
    .wr_en   (in_xfer),
    .wr_addr (cnt_r),
    .wr_data (texel_rgb),
    .rd_en   (rd_en),
    .rd_addr (rd_cnt_r[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  bc1pt_select u_sel (
    .clk      (clk),
    .rst_n    (rst_n),
    .sw_in    (rd_sw_r),
    .texel    (rd_data),
    .pal      (pal),
    .sw_out   (sw_out),
    .sel_code (sel_code)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_LOAD;
      thresh_r      <= THRESH_RESET;
      cnt_r         <= '0;
      rd_cnt_r      <= '0;
      mask_r        <= '0;
      min_r         <= '1;
      max_r         <= '0;
      opaque_r      <= 1'b0;
      rd_sw_r.valid <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        thresh_r <= cfg_wr_data;
      end

      // read data tag follows the memory latency
      rd_sw_r.valid <= rd_en;
      rd_sw_r.idx   <= rd_cnt_r[IDX_W-1:0];

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_LOAD: begin
          if (in_xfer) begin
            cnt_r  <= cnt_r + 1'b1;
            mask_r <= mask_nxt;
            if (!texel_clear) begin
              for (int c = 0; c < 3; c++) begin
                if (texel_rgb[c] < min_r[c]) min_r[c] <= texel_rgb[c];
                if (texel_rgb[c] > max_r[c]) max_r[c] <= texel_rgb[c];
              end
            end
            if (cnt_r == LAST_IDX) begin
              opaque_r <= (mask_nxt == '0);
              state_r  <= (mask_nxt == '0) ? S_DONE : S_ENDP;
            end
          end
        end
        S_ENDP: begin
          // order endpoints so color0 <= color1
          ep0_r    <= (c_lo > c_hi) ? c_hi : c_lo;
          ep1_r    <= (c_lo > c_hi) ? c_lo : c_hi;
          rd_cnt_r <= '0;
          state_r  <= S_SWEEP;
        end
        S_SWEEP: begin
          if (rd_en) begin
            rd_cnt_r <= rd_cnt_r + 1'b1;
          end
          if (sw_out.valid) begin
            sel_r[{sw_out.idx, 1'b0} +: 2] <= mask_r[sw_out.idx] ? SEL_CLEAR : sel_code;
            if (sw_out.idx == LAST_IDX) begin
              state_r <= S_DONE;
            end
          end
        end
        S_DONE: begin
          // hand over once the output register is free, then reload block state
          if (out_load) begin
            out_data_r.all_opaque      <= opaque_r;
            out_data_r.endpoint_first  <= opaque_r ? '0 : ep0_r;
            out_data_r.endpoint_second <= opaque_r ? '0 : ep1_r;
            out_data_r.selector_bits   <= opaque_r ? '0 : sel_r;
            mask_r                     <= '0;
            min_r                      <= '1;
            max_r                      <= '0;
            state_r                    <= S_LOAD;
          end
        end
        default: begin
          state_r <= S_LOAD;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  // memory reads and writes never overlap, so no forwarding is needed
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_xfer && rd_en))
    else $error("texel memory read during load");

  // the match pipeline only delivers during the sweep
  a_sel_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    sw_out.valid |-> (state_r == S_SWEEP))
    else $error("selector result outside sweep");

  // a sweep always starts at texel zero
  a_sweep_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ENDP) |=> (rd_cnt_r == '0) && (cnt_r == '0))
    else $error("sweep does not start at texel zero");

  // endpoints come out ordered
  a_ep_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.all_opaque) |->
      (out_data_r.endpoint_first <= out_data_r.endpoint_second))
    else $error("endpoints out of order");

  // an opaque block carries zero fields
  a_opaque_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.all_opaque) |->
      (out_data_r.selector_bits == '0) && (out_data_r.endpoint_first == '0) &&
      (out_data_r.endpoint_second == '0))
    else $error("opaque block with nonzero fields");
`endif

endmodule

FILE: rtl/core/bc1pt_texel_mem.sv
// texel store: 16 x 24 bit synchronous memory, one write and one registered read port
module bc1pt_texel_mem
  import bc1pt_pkg::*;
(
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  rgb_t             wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output rgb_t             rd_data
);

  rgb_t mem_r [TEXELS];
  rgb_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/core/bc1pt_select.sv
// per-texel palette match: registered squared differences, then sum and least-error pick
module bc1pt_select
  import bc1pt_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  sweep_t sw_in,
  input  rgb_t   texel,
  input  pal_t   pal,
  output sweep_t sw_out,
  output logic [1:0] sel_code
);

  logic [2:0][2:0][SQ_W-1:0] sq_r;
  sweep_t                    sw_r;
  logic [2:0][2:0][SQ_W-1:0] sq;
  logic [2:0][ERR_W-1:0]     err;

  function automatic logic [SQ_W-1:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    return SQ_W'(d) * SQ_W'(d);
  endfunction

  always_comb begin
    for (int p = 0; p < 3; p++) begin
      for (int c = 0; c < 3; c++) begin
        sq[p][c] = sq_diff(texel[c], pal[p][c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r.valid <= 1'b0;
    end else begin
      sw_r.valid <= sw_in.valid;
    end
    sw_r.idx <= sw_in.idx;
    sq_r     <= sq;
  end

  always_comb begin
    for (int p = 0; p < 3; p++) begin
      err[p] = ERR_W'(sq_r[p][0]) + ERR_W'(sq_r[p][1]) + ERR_W'(sq_r[p][2]);
    end
  end

  // strict compare keeps ties on the lower entry
  always_comb begin
    logic [ERR_W-1:0] best;
    best     = err[0];
    sel_code = SEL_EP0;
    if (err[1] < best) begin
      best     = err[1];
      sel_code = SEL_EP1;
    end
    if (err[2] < best) begin
      sel_code = SEL_MID;
    end
  end

  assign sw_out = sw_r;

endmodule

FILE: tb/sv/bc1_punch_through_block_encoder_tb.sv
// self-checking testbench for the punch-through 4x4 block encoder
module bc1_punch_through_block_encoder_tb
  import bc1pt_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // kinds of generated blocks, by how their texels split into clear and opaque
  typedef enum int {
    KIND_OPAQUE,
    KIND_CLEAR,
    KIND_MIXED,
    KIND_SPARSE,
    KIND_CLUSTER
  } block_kind_t;

  logic       clk;
  logic       rst_n       = 1'b0;
  logic       in_valid    = 1'b0;
  logic       in_stall;
  texel_in_t  in_data     = '0;
  logic       out_valid;
  logic       out_stall   = 1'b0;
  block_out_t out_data;
  logic       cfg_wr_en   = 1'b0;
  logic [7:0] cfg_wr_data = '0;

  bc1_punch_through_block_encoder i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // texels waiting to be offered, and block results still owed by the encoder
  texel_in_t  texel_queue[$];
  block_out_t block_results[$];

  int unsigned items_pushed   = 0;
  int unsigned items_accepted = 0;
  int unsigned fail_count     = 0;

  // traffic shaping, set by the stimulus and monitor at rising edges, read at falling edges
  int send_idle_pct = 0;
  int stall_pct     = 0;
  bit pressure_on   = 1'b0;
  bit hold_off      = 1'b0;
  bit in_taken      = 1'b0;

  // predictor state: threshold copy, texel memory, clear mask, opaque min/max
  logic [7:0]       alpha_cut = THRESH_RESET;
  rgb_t             texel_mem [TEXELS];
  logic [15:0]      clear_bits = '0;
  rgb_t             lo_acc     = '1;
  rgb_t             hi_acc     = '0;
  logic [IDX_W-1:0] fill_pos   = '0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // RGB565 word back to 8-bit channels by bit replication
  function automatic rgb_t widen565(input logic [15:0] w);
    rgb_t c;
    c[0] = {w[15:11], w[15:13]};
    c[1] = {w[10:5], w[10:9]};
    c[2] = {w[4:0], w[4:2]};
    return c;
  endfunction

  // full block result from the accumulated texels
  function automatic block_out_t encode_block();
    block_out_t r;
    rgb_t       lo;
    rgb_t       hi;
    pal_t       pal;
    logic [15:0] c0;
    logic [15:0] c1;
    logic [15:0] tmp;
    int         err [3];
    int         best;
    int         d;
    logic [1:0] pick;
    r = '0;
    // no clear texel: only the flag, the opaque path lives elsewhere
    if (clear_bits == '0) begin
      r.all_opaque = 1'b1;
      return r;
    end
    // all clear: min/max never moved, endpoints forced to zero
    lo = (clear_bits == MASK_ALL) ? '0 : lo_acc;
    hi = (clear_bits == MASK_ALL) ? '0 : hi_acc;
    c0 = {lo[0][7:3], lo[1][7:2], lo[2][7:3]};
    c1 = {hi[0][7:3], hi[1][7:2], hi[2][7:3]};
    // 3-color mode needs color0 <= color1
    if (c0 > c1) begin
      tmp = c0;
      c0  = c1;
      c1  = tmp;
    end
    pal[0] = widen565(c0);
    pal[1] = widen565(c1);
    for (int ch = 0; ch < 3; ch++) begin
      pal[2][ch] = 8'((9'(pal[0][ch]) + 9'(pal[1][ch])) >> 1);
    end
    r.endpoint_first  = c0;
    r.endpoint_second = c1;
    for (int i = 0; i < TEXELS; i++) begin
      if (clear_bits[i]) begin
        pick = SEL_CLEAR;
      end else begin
        for (int p = 0; p < 3; p++) begin
          err[p] = 0;
          for (int ch = 0; ch < 3; ch++) begin
            d = int'(texel_mem[i][ch]) - int'(pal[p][ch]);
            err[p] += d * d;
          end
        end
        // strict compare keeps ties on the lower entry
        best = err[0];
        pick = SEL_EP0;
        if (err[1] < best) begin
          best = err[1];
          pick = SEL_EP1;
        end
        if (err[2] < best) begin
          pick = SEL_MID;
        end
      end
      r.selector_bits[2*i +: 2] = pick;
    end
    return r;
  endfunction

  // one accepted texel into the predictor; the 16th one yields a result
  task automatic absorb_texel(input texel_in_t t);
    rgb_t c;
    c[0] = t.red;
    c[1] = t.green;
    c[2] = t.blue;
    texel_mem[fill_pos] = c;
    if (t.alpha < alpha_cut) begin
      clear_bits[fill_pos] = 1'b1;
    end else begin
      for (int ch = 0; ch < 3; ch++) begin
        if (c[ch] < lo_acc[ch]) lo_acc[ch] = c[ch];
        if (c[ch] > hi_acc[ch]) hi_acc[ch] = c[ch];
      end
    end
    if (fill_pos == LAST_IDX) begin
      block_results.push_back(encode_block());
      clear_bits = '0;
      lo_acc     = '1;
      hi_acc     = '0;
    end
    fill_pos = fill_pos + 1'b1;
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // monitor: both channels sampled at the rising edge
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    block_out_t want;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      // input transfer feeds the predictor
      if (in_valid && !in_stall) begin
        absorb_texel(in_data);
        items_accepted++;
      end
      // output transfer checked against the oldest expected block
      if (out_valid && !out_stall) begin
        if (block_results.size() == 0) begin
          $display("%0t: result transfer with nothing expected, actual %0h",
                   $time, out_data);
          fail_count++;
        end else begin
          want = block_results.pop_front();
          compare_field("endpoint_first", 32'(want.endpoint_first),
                        32'(out_data.endpoint_first));
          compare_field("endpoint_second", 32'(want.endpoint_second),
                        32'(out_data.endpoint_second));
          compare_field("selector_bits", want.selector_bits, out_data.selector_bits);
          compare_field("all_opaque", 32'(want.all_opaque), 32'(out_data.all_opaque));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // driver: texels leave the queue at the falling edge
  // ---------------------------------------------------------------------------

  // a new texel is put up only once the previous one is gone, so a stalled
  // payload holds; the idle draw never looks at in_stall
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (texel_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= texel_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall: random per phase, forced high during the long hold-off
  always @(negedge clk) begin
    out_stall <= hold_off || ($urandom_range(99) < stall_pct);
  end

  // long hold-off on the result side while texels keep coming, so the output
  // register stays full, the next block finishes behind it and the input stalls
  initial begin
    wait (pressure_on);
    repeat (10) @(posedge clk);
    hold_off = 1'b1;
    repeat (400) @(posedge clk);
    hold_off = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  task automatic push_texel(input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b, input logic [7:0] a);
    texel_in_t t;
    t = '{red: r, green: g, blue: b, alpha: a};
    texel_queue.push_back(t);
    items_pushed++;
  endtask

  // alpha on the requested side of the threshold, often right at the edge;
  // with a zero threshold nothing can be clear, so it falls back to opaque
  function automatic logic [7:0] pick_alpha(input bit clear);
    int a;
    if (clear && alpha_cut != 0) begin
      case ($urandom_range(3))
        0:       a = int'(alpha_cut) - 1;
        1:       a = 0;
        default: a = $urandom_range(int'(alpha_cut) - 1, 0);
      endcase
    end else begin
      case ($urandom_range(3))
        0:       a = int'(alpha_cut);
        1:       a = 255;
        default: a = $urandom_range(255, int'(alpha_cut));
      endcase
    end
    return 8'(a);
  endfunction

  function automatic block_kind_t pick_kind();
    case ($urandom_range(9))
      0, 1:    return KIND_OPAQUE;
      2:       return KIND_CLEAR;
      6, 7:    return KIND_SPARSE;
      8, 9:    return KIND_CLUSTER;
      default: return KIND_MIXED;
    endcase
  endfunction

  // sixteen texels of one random block
  task automatic queue_block(input block_kind_t kind);
    logic [15:0] clear_pick;
    int          base [3];
    int          v [3];
    clear_pick = '0;
    for (int ch = 0; ch < 3; ch++) base[ch] = $urandom_range(255);
    case (kind)
      KIND_OPAQUE: clear_pick = '0;
      KIND_CLEAR:  clear_pick = MASK_ALL;
      KIND_SPARSE: begin
        repeat ($urandom_range(3, 1)) clear_pick[$urandom_range(15)] = 1'b1;
      end
      KIND_CLUSTER: begin
        for (int i = 0; i < TEXELS; i++) clear_pick[i] = ($urandom_range(3) == 0);
      end
      default: clear_pick = 16'($urandom);
    endcase
    for (int i = 0; i < TEXELS; i++) begin
      for (int ch = 0; ch < 3; ch++) begin
        if (kind == KIND_CLUSTER) begin
          // close colors land on midpoints and error ties
          v[ch] = base[ch] + int'($urandom_range(12)) - 6;
          if (v[ch] < 0) v[ch] = 0;
          if (v[ch] > 255) v[ch] = 255;
        end else if ($urandom_range(3) == 0) begin
          v[ch] = $urandom_range(1) ? 255 : 0;
        end else begin
          v[ch] = $urandom_range(255);
        end
      end
      push_texel(8'(v[0]), 8'(v[1]), 8'(v[2]), pick_alpha(clear_pick[i]));
    end
  endtask

  // waits until every texel is taken and every block result checked, then lets
  // the encoder settle
  task automatic wait_drained();
    @(negedge clk);
    while (items_accepted != items_pushed || block_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (40) @(negedge clk);
  endtask

  // threshold write, only while the encoder is idle
  task automatic write_threshold(input logic [7:0] value);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    alpha_cut = value;
  endtask

  task automatic run_phase(input logic [7:0] cut, input int send_pct,
                           input int stall_pct_i, input int n_blocks,
                           input bit pressure);
    write_threshold(cut);
    @(posedge clk);
    send_idle_pct = send_pct;
    stall_pct     = stall_pct_i;
    pressure_on   = pressure;
    repeat (n_blocks) queue_block(pick_kind());
    wait_drained();
  endtask

  initial begin
    // synchronous reset, released at a falling edge
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed blocks at the reset threshold of 128, no idling
    // mixed block: alpha just under and at the threshold, channel extremes
    push_texel(8'd0, 8'd0, 8'd0, 8'd127);
    push_texel(8'd255, 8'd255, 8'd255, 8'd128);
    push_texel(8'd0, 8'd0, 8'd0, 8'd255);
    push_texel(8'd255, 8'd0, 8'd0, 8'd255);
    push_texel(8'd0, 8'd255, 8'd0, 8'd255);
    push_texel(8'd0, 8'd0, 8'd255, 8'd255);
    push_texel(8'd255, 8'd255, 8'd255, 8'd0);
    for (int i = 7; i < TEXELS; i++) begin
      push_texel(8'(i * 17), 8'(255 - i * 17), 8'(i * 29), 8'd200);
    end
    // fully transparent block: zero endpoints, every selector clear
    for (int i = 0; i < TEXELS; i++) begin
      push_texel(i[0] ? 8'd255 : 8'd0, 8'd255, i[1] ? 8'd255 : 8'd0,
                 i[0] ? 8'd127 : 8'd0);
    end
    // fully opaque block: only the flag comes back
    for (int i = 0; i < TEXELS; i++) begin
      push_texel(8'(i * 16), 8'(255 - i * 16), i[0] ? 8'd255 : 8'd0,
                 i[0] ? 8'd128 : 8'd255);
    end
    wait_drained();

    // random blocks over several thresholds and traffic patterns
    run_phase(8'd255, 0, 0, 5, 1'b0);
    run_phase(8'd0, 81, 0, 3, 1'b0);                 // nothing can be clear
    run_phase(8'd1, 0, 81, 6, 1'b0);
    run_phase(8'($urandom_range(254, 2)), 25, 25, 8, 1'b0);
    run_phase(THRESH_RESET, 0, 0, 7, 1'b1);          // output hold-off
    run_phase(8'($urandom_range(255)), 0, 0, 8, 1'b0);

    if (fail_count == 0) begin
      $display("[bc1_punch_through_block_encoder] OK");
    end else begin
      $display("[bc1_punch_through_block_encoder] ERROR");
    end
    $finish;
  end

  // run limit, far above the slowest correct run
  initial begin
    #2_000_000;
    $display("[bc1_punch_through_block_encoder] ERROR");
    $finish;
  end

endmodule
